// ===== sv/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Types and constants shared by the command line tokenizer and its channels.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int unsigned LineMaxDef = 256;
  localparam int unsigned ChW        = 8;
  localparam int unsigned CapW       = 9;
  localparam int unsigned LenW       = 9;
  localparam int unsigned OutPosW    = 8;
  localparam logic [CapW-1:0] HexCapRst = 9'd64;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_TOKEN  = 2'd1,
    ST_BAD_VALUE  = 2'd2,
    ST_UNEXPECTED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_HEX   = 2'd2,
    MODE_END   = 2'd3
  } mode_e;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic [1:0]     op;
    logic           line_end;
  } in_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data_byte;
    logic [OutPosW-1:0] token_start;
    logic [LenW-1:0]    token_length;
    status_e            status;
    logic [OutPosW-1:0] error_position;
    logic               run_last;
  } out_word_t;

  typedef logic [CapW-1:0] cfg_word_t;

endpackage

// ===== sv/clt_stream_if.sv =====
// ----------------------------------------------------------------------------
// clt_stream_if
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
interface clt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/command_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a command line, one character per word, into plain, identifier,
// hex byte tokens, with a token opened in end mode reported as unexpected;
// emits decoded bytes and token reports.
//  channel   dir   word          notes
//  in_if     in    in_word_t     one character, scan mode, line end flag
//  out_if    out   out_word_t    hex byte or token report, up to 2 per char
//  cfg_if    in    cfg_word_t    hex_capacity, always ready
//
//  One character is taken per cycle while at least two entries of the
//  4-entry output queue are free; its state update is done in that cycle.
//  Results go to that queue. Stalls on out_if back up into in_if through
//  the queue.
//  Reset clears the line state and loads hex_capacity with 64.
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
  parameter int unsigned LINE_MAX = clt_pkg::LineMaxDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clt_stream_if.sink   in_if,
  clt_stream_if.source out_if,
  clt_stream_if.sink   cfg_if
);
  import clt_pkg::*;

  localparam int unsigned PosW = $clog2(LINE_MAX);
  localparam int unsigned ExtW = (PosW + 1 > LenW) ? PosW + 1 : LenW;
  localparam logic [PosW-1:0] PosMax = PosW'(LINE_MAX - 1);

  function automatic logic [4:0] hex_value(input logic [ChW-1:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= "0" && c <= "9") begin
      v = 5'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      v = 5'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      v = 5'(c - "A" + 8'd10);
    end
    return v;
  endfunction

  function automatic logic [OutPosW-1:0] pos_out(input logic [PosW-1:0] p);
    logic [ExtW-1:0] e;
    e = ExtW'(p);
    return e[OutPosW-1:0];
  endfunction

  // Line state
  status_e         line_status_q, line_status_d;
  logic            in_token_q, in_token_d;
  mode_e           mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] start_q, start_d;
  logic            np_q, np_d;
  logic [3:0]      hn_q, hn_d;
  logic [CapW-1:0] bc_q, bc_d;
  cfg_word_t       cap_q;

  // Output queue
  out_word_t  fifo_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q, cnt_d;

  logic       acc, pop, ws, last, first, active, is_letter, is_dec;
  logic [4:0] hv;
  mode_e      mode;
  logic [PosW-1:0] st_pos;
  logic [CapW-1:0] bc, bc_new;
  logic [ExtW-1:0] here;
  logic       fin, byte_out;
  status_e    fin_st;
  logic [ExtW-1:0] fin_len;
  out_word_t  byte_res, fin_res, res0, res1;
  logic [1:0] n_push;

  assign in_if.ready  = (cnt_q < 3'd3);
  assign cfg_if.ready = 1'b1;
  assign acc          = in_if.valid & in_if.ready;
  assign pop          = out_if.valid & out_if.ready;
  assign out_if.valid = (cnt_q != 3'd0);
  assign out_if.data  = fifo_q[rp_q];

  always_comb begin
    ws = (in_if.data.ch == 8'h0d) || (in_if.data.ch == 8'h0a) ||
         (in_if.data.ch == 8'h09) || (in_if.data.ch == 8'h20);
    last      = in_if.data.line_end;
    is_letter = (in_if.data.ch >= "a" && in_if.data.ch <= "z") ||
                (in_if.data.ch >= "A" && in_if.data.ch <= "Z") ||
                (in_if.data.ch == "_");
    is_dec    = (in_if.data.ch >= "0" && in_if.data.ch <= "9");
    hv        = hex_value(in_if.data.ch);
    active    = (line_status_q == ST_OK) && (in_token_q || !ws);
    first     = !in_token_q;
    mode      = in_token_q ? mode_q : mode_e'(in_if.data.op);
    st_pos    = in_token_q ? start_q : pos_q;
    bc        = in_token_q ? bc_q : '0;
    here      = ExtW'(pos_q) - ExtW'(st_pos);

    fin      = 1'b0;
    fin_st   = ST_OK;
    fin_len  = '0;
    byte_out = 1'b0;
    bc_new   = bc;
    np_d     = in_token_q ? np_q : 1'b0;
    hn_d     = hn_q;

    case (mode)
      MODE_PLAIN: begin
        if (ws) begin
          fin = 1'b1; fin_len = here;
        end else if (last) begin
          fin = 1'b1; fin_len = here + ExtW'(1);
        end
      end
      MODE_IDENT: begin
        if (ws) begin
          fin = 1'b1; fin_len = here;
        end else if (is_letter || (!first && is_dec)) begin
          if (last) begin
            fin = 1'b1; fin_len = here + ExtW'(1);
          end
        end else begin
          fin = 1'b1; fin_st = ST_BAD_TOKEN; fin_len = here;
        end
      end
      MODE_HEX: begin
        if (np_d) begin
          np_d = 1'b0;
          if (!hv[4]) begin
            bc_new   = bc + CapW'(1);
            byte_out = 1'b1;
            if (last) begin
              fin = 1'b1; fin_len = ExtW'(bc_new);
            end
          end else begin
            fin = 1'b1; fin_st = ST_BAD_TOKEN; fin_len = ExtW'(bc);
          end
        end else if (ws) begin
          fin = 1'b1; fin_len = ExtW'(bc);
        end else if (last || hv[4]) begin
          fin = 1'b1; fin_st = ST_BAD_TOKEN; fin_len = ExtW'(bc);
        end else if (bc >= cap_q) begin
          fin = 1'b1; fin_st = ST_BAD_VALUE; fin_len = ExtW'(bc);
        end else begin
          hn_d = hv[3:0];
          np_d = 1'b1;
        end
      end
      default: begin
        fin = 1'b1; fin_st = ST_UNEXPECTED; fin_len = '0;
      end
    endcase

    byte_res.kind           = KIND_BYTE;
    byte_res.data_byte      = {hn_q, hv[3:0]};
    byte_res.token_start    = pos_out(st_pos);
    byte_res.token_length   = bc_new;
    byte_res.status         = ST_OK;
    byte_res.error_position = pos_out(pos_q);
    byte_res.run_last       = !fin;

    fin_res.kind            = KIND_REPORT;
    fin_res.data_byte       = '0;
    fin_res.token_start     = pos_out(st_pos);
    fin_res.token_length    = fin_len[LenW-1:0];
    fin_res.status          = fin_st;
    fin_res.error_position  = (fin_st == ST_BAD_VALUE) ? pos_out(st_pos) : pos_out(pos_q);
    fin_res.run_last        = 1'b1;

    res0   = byte_out ? byte_res : fin_res;
    res1   = fin_res;
    n_push = (acc && active) ? (2'(byte_out) + 2'(fin)) : 2'd0;

    // Next line state
    line_status_d = line_status_q;
    in_token_d    = in_token_q;
    mode_d        = mode_q;
    start_d       = start_q;
    bc_d          = bc_q;
    if (active) begin
      line_status_d = fin ? fin_st : ST_OK;
      in_token_d    = !fin;
      mode_d        = mode;
      start_d       = st_pos;
      bc_d          = bc_new;
    end else begin
      np_d = np_q;
      hn_d = hn_q;
    end
    pos_d = (pos_q < PosMax) ? pos_q + PosW'(1) : pos_q;
    if (last) begin
      line_status_d = ST_OK;
      in_token_d    = 1'b0;
      mode_d        = MODE_PLAIN;
      pos_d         = '0;
      start_d       = '0;
      np_d          = 1'b0;
      hn_d          = '0;
      bc_d          = '0;
    end

    cnt_d = cnt_q + 3'(n_push) - 3'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_status_q <= ST_OK;
      in_token_q    <= 1'b0;
      mode_q        <= MODE_PLAIN;
      pos_q         <= '0;
      start_q       <= '0;
      np_q          <= 1'b0;
      hn_q          <= '0;
      bc_q          <= '0;
      cap_q         <= HexCapRst;
      wp_q          <= '0;
      rp_q          <= '0;
      cnt_q         <= '0;
    end else begin
      if (acc) begin
        line_status_q <= line_status_d;
        in_token_q    <= in_token_d;
        mode_q        <= mode_d;
        pos_q         <= pos_d;
        start_q       <= start_d;
        np_q          <= np_d;
        hn_q          <= hn_d;
        bc_q          <= bc_d;
      end
      if (cfg_if.valid) begin
        cap_q <= cfg_if.data;
      end
      wp_q  <= wp_q + n_push;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wp_q] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wp_q + 2'd1] <= res1;
    end
  end

endmodule
